// ===== design/dvrt_pkg.sv =====
`default_nettype none

package dvrt_pkg;

  // Fixed field widths of the request and response
  localparam int TYPE_W  = 2;
  localparam int NODE_W  = 4;
  localparam int GATE_W  = 3;
  localparam int COST_W  = 8;
  localparam int ACT_W   = 2;
  localparam int TOTAL_W = COST_W + 1;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_NODES = 16;
  localparam int DEF_NUM_GATES = 8;
  localparam int DEF_COST_BITS = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DUMP_MAX      = 16;

  // Request types
  localparam logic [TYPE_W-1:0] REQ_HELLO = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_DV    = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_PKT   = 2'd2;

  // Response actions
  localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOCAL   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_ENTRY   = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [NODE_W-1:0] sender_node;
    logic [GATE_W-1:0] arrival_gate;
    logic [NODE_W-1:0] destination;
    logic [COST_W-1:0] advertised_cost;
    logic              last_entry;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [GATE_W-1:0] out_gate;
    logic [NODE_W-1:0] dest_node;
    logic [COST_W-1:0] route_cost;
    logic              last;
  } rsp_t;

  typedef enum logic [1:0] {
    JOB_HELLO,
    JOB_DV,
    JOB_PKT
  } job_kind_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    job_kind_t          kind;
    logic               install;    // hello/DV passes all range and own-node checks
    logic               local_dst;  // packet for this node
    logic               dest_in;    // destination inside the table
    logic               last_entry;
    logic [NODE_W-1:0]  sender;
    logic [GATE_W-1:0]  gate;
    logic [NODE_W-1:0]  dest;
    logic [TOTAL_W-1:0] total;      // advertised cost plus one hop
  } job_t;

endpackage

`default_nettype wire

// ===== design/dvrt_front.sv =====
`default_nettype none

module dvrt_front #(
  parameter int NUM_NODES = dvrt_pkg::DEF_NUM_NODES,
  parameter int NUM_GATES = dvrt_pkg::DEF_NUM_GATES,
  parameter int COST_BITS = dvrt_pkg::DEF_COST_BITS
) (
  input  wire logic                        start,
  input  wire dvrt_pkg::req_t              req,
  input  wire logic [dvrt_pkg::NODE_W-1:0] own_node_id,
  input  wire logic                        q_full,
  output logic                             busy,
  output logic                             push,
  output dvrt_pkg::job_t                   job
);

  localparam int COST_MAX = (1 << COST_BITS) - 1;

  logic [dvrt_pkg::TOTAL_W-1:0] total;
  logic                         sender_ok;
  logic                         dest_in;
  logic                         dest_own;
  logic                         known_type;

  // Range checks shared by all request types
  always_comb begin
    total     = dvrt_pkg::TOTAL_W'(req.advertised_cost) + dvrt_pkg::TOTAL_W'(1);
    sender_ok = (int'(req.sender_node) < NUM_NODES) && (int'(req.arrival_gate) < NUM_GATES);
    dest_in   = int'(req.destination) < NUM_NODES;
    dest_own  = req.destination == own_node_id;
  end

  // Classification into a queue job
  always_comb begin
    job.kind       = dvrt_pkg::JOB_HELLO;
    job.install    = 1'b0;
    job.local_dst  = dest_own;
    job.dest_in    = dest_in;
    job.last_entry = req.last_entry;
    job.sender     = req.sender_node;
    job.gate       = req.arrival_gate;
    job.dest       = req.destination;
    job.total      = total;
    known_type     = 1'b1;
    case (req.req_type)
      dvrt_pkg::REQ_HELLO: begin
        job.kind    = dvrt_pkg::JOB_HELLO;
        job.install = sender_ok && (req.sender_node != own_node_id);
      end
      dvrt_pkg::REQ_DV: begin
        job.kind    = dvrt_pkg::JOB_DV;
        job.install = sender_ok && dest_in && !dest_own && (int'(total) <= COST_MAX);
      end
      dvrt_pkg::REQ_PKT: begin
        job.kind = dvrt_pkg::JOB_PKT;
      end
      default: begin
        known_type = 1'b0;  // unused type: accepted and dropped
      end
    endcase
  end

  assign busy = q_full;
  assign push = start && !q_full && known_type;

endmodule

`default_nettype wire

// ===== design/dvrt_queue.sv =====
`default_nettype none

module dvrt_queue #(
  parameter int DEPTH = dvrt_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dvrt_pkg::job_t wr_job,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output dvrt_pkg::job_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dvrt_pkg::job_t  slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = int'(count) == DEPTH;
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/dvrt_back.sv =====
`default_nettype none

module dvrt_back #(
  parameter int NUM_NODES = dvrt_pkg::DEF_NUM_NODES,
  parameter int COST_BITS = dvrt_pkg::DEF_COST_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dvrt_pkg::NODE_W-1:0] own_node_id,
  input  wire logic                        q_empty,
  input  wire dvrt_pkg::job_t              q_job,
  output logic                             q_pop,
  output logic                             rsp_valid,
  output dvrt_pkg::rsp_t                   rsp
);

  localparam int IDX_W      = $clog2(NUM_NODES);
  localparam int DUMP_LIMIT = (NUM_NODES < dvrt_pkg::DUMP_MAX) ? NUM_NODES : dvrt_pkg::DUMP_MAX;
  localparam int CNT_W      = $clog2(DUMP_LIMIT + 1);
  localparam int CMP_W      = (COST_BITS > dvrt_pkg::TOTAL_W) ? COST_BITS : dvrt_pkg::TOTAL_W;

  typedef struct packed {
    logic [COST_BITS-1:0]        cost;
    logic [dvrt_pkg::NODE_W-1:0] hop;
  } route_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DV,
    S_PKT_HOP,
    S_PKT_OUT,
    S_DUMP
  } state_t;

  function automatic dvrt_pkg::rsp_t make_rsp(
    input logic [dvrt_pkg::ACT_W-1:0]  act,
    input logic [dvrt_pkg::GATE_W-1:0] gate,
    input logic [dvrt_pkg::NODE_W-1:0] node,
    input logic [dvrt_pkg::COST_W-1:0] cost,
    input logic                        fin
  );
    dvrt_pkg::rsp_t r;
    r.action     = act;
    r.out_gate   = gate;
    r.dest_node  = node;
    r.route_cost = cost;
    r.last       = fin;
    return r;
  endfunction

  state_t                        state;
  dvrt_pkg::job_t                cur;
  logic                          change_pending;

  // Route and neighbor tables: valid bits in flops, payload in memories
  logic [NUM_NODES-1:0]          rvalid;
  logic [NUM_NODES-1:0]          nvalid;
  route_t                        route_mem [NUM_NODES];
  logic [dvrt_pkg::GATE_W-1:0]   nb_mem    [NUM_NODES];
  route_t                        route_rd;
  logic [dvrt_pkg::GATE_W-1:0]   nb_rd;

  // Dump walk: address stage, then hold one entry to find the last one
  logic [CNT_W-1:0]              dump_cnt;
  logic                          s1_live;
  logic                          s1_own;
  logic [dvrt_pkg::NODE_W-1:0]   s1_node;
  logic                          pend_valid;
  logic [dvrt_pkg::NODE_W-1:0]   pend_node;
  logic [dvrt_pkg::COST_W-1:0]   pend_cost;

  logic [IDX_W-1:0]              cur_dest_idx;
  logic [IDX_W-1:0]              head_dest_idx;
  logic [IDX_W-1:0]              head_sender_idx;
  logic [IDX_W-1:0]              cur_sender_idx;
  logic [IDX_W-1:0]              hop_idx;
  logic [IDX_W-1:0]              dump_idx;
  logic [CMP_W-1:0]              cost_cmp;
  logic [CMP_W-1:0]              total_cmp;
  logic                          cur_rv;
  logic                          hop_ok;
  logic                          dv_insert;
  logic                          dv_raise;
  logic                          hello_wr;
  logic                          dump_own;
  logic                          dump_hit;
  logic                          dump_done;

  logic                          route_we;
  logic [IDX_W-1:0]              route_wa;
  route_t                        route_wd;
  logic [IDX_W-1:0]              route_ra;
  logic                          nb_we;
  logic [IDX_W-1:0]              nb_wa;
  logic [dvrt_pkg::GATE_W-1:0]   nb_wd;

  // Indexes and compares
  always_comb begin
    cur_dest_idx    = IDX_W'(cur.dest);
    cur_sender_idx  = IDX_W'(cur.sender);
    head_dest_idx   = IDX_W'(q_job.dest);
    head_sender_idx = IDX_W'(q_job.sender);
    hop_idx         = IDX_W'(route_rd.hop);
    dump_idx        = IDX_W'(dump_cnt);
    cost_cmp        = CMP_W'(route_rd.cost);
    total_cmp       = CMP_W'(cur.total);
    cur_rv          = cur.dest_in && rvalid[cur_dest_idx];
    hop_ok          = (int'(route_rd.hop) < NUM_NODES) && nvalid[hop_idx];
    dump_own        = int'(dump_cnt) == int'(own_node_id);
    dump_done       = int'(dump_cnt) == DUMP_LIMIT;
    dump_hit        = !dump_done && (dump_own || rvalid[dump_idx]);
  end

  // Table update decisions
  always_comb begin
    q_pop     = (state == S_IDLE) && !q_empty;
    hello_wr  = q_pop && (q_job.kind == dvrt_pkg::JOB_HELLO) && q_job.install;
    dv_insert = (state == S_DV) && cur.install && (!cur_rv || (total_cmp < cost_cmp));
    dv_raise  = (state == S_DV) && cur.install && !dv_insert && cur_rv
                && (route_rd.hop == cur.sender) && (total_cmp > cost_cmp);

    route_we = hello_wr || dv_insert || dv_raise;
    nb_we    = hello_wr || dv_insert;
    if (hello_wr) begin
      route_wa      = head_sender_idx;
      route_wd.cost = COST_BITS'(1);
      route_wd.hop  = q_job.sender;
      nb_wa         = head_sender_idx;
      nb_wd         = q_job.gate;
    end else begin
      route_wa      = cur_dest_idx;
      route_wd.cost = COST_BITS'(cur.total);
      route_wd.hop  = cur.sender;
      nb_wa         = cur_sender_idx;
      nb_wd         = cur.gate;
    end
    route_ra = (state == S_IDLE) ? head_dest_idx : dump_idx;
  end

  // Table memories, registered reads
  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_wa] <= route_wd;
    end
    route_rd <= route_mem[route_ra];
    if (nb_we) begin
      nb_mem[nb_wa] <= nb_wd;
    end
    nb_rd <= nb_mem[hop_idx];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
      nvalid <= '0;
    end else begin
      if (route_we) begin
        rvalid[route_wa] <= 1'b1;
      end
      if (nb_we) begin
        nvalid[nb_wa] <= 1'b1;
      end
    end
  end

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      change_pending <= 1'b0;
      s1_live        <= 1'b0;
      pend_valid     <= 1'b0;
      dump_cnt       <= '0;
    end else begin
      rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_job;
            case (q_job.kind)
              dvrt_pkg::JOB_HELLO: begin
                dump_cnt <= '0;
                state    <= S_DUMP;
              end
              dvrt_pkg::JOB_DV: begin
                state <= S_DV;
              end
              dvrt_pkg::JOB_PKT: begin
                if (q_job.local_dst) begin
                  rsp_valid <= 1'b1;
                  rsp       <= make_rsp(dvrt_pkg::ACT_LOCAL, '0, q_job.dest, '0, 1'b1);
                end else begin
                  state <= S_PKT_HOP;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DV: begin
          if (cur.last_entry) begin
            change_pending <= 1'b0;
            if (change_pending || dv_insert || dv_raise) begin
              dump_cnt <= '0;
              state    <= S_DUMP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            change_pending <= change_pending || dv_insert || dv_raise;
            state          <= S_IDLE;
          end
        end
        S_PKT_HOP: begin
          if (cur_rv && hop_ok) begin
            state <= S_PKT_OUT;
          end else begin
            rsp_valid <= 1'b1;
            rsp       <= make_rsp(dvrt_pkg::ACT_DROP, '0, cur.dest, '0, 1'b1);
            state     <= S_IDLE;
          end
        end
        S_PKT_OUT: begin
          rsp_valid <= 1'b1;
          rsp       <= make_rsp(dvrt_pkg::ACT_FORWARD, nb_rd, cur.dest, '0, 1'b1);
          state     <= S_IDLE;
        end
        S_DUMP: begin
          // address stage
          if (!dump_done) begin
            dump_cnt <= dump_cnt + CNT_W'(1);
          end
          s1_live <= dump_hit;
          s1_own  <= dump_own;
          s1_node <= dvrt_pkg::NODE_W'(dump_cnt);
          // data stage: send the held entry once a later one shows up
          if (s1_live) begin
            if (pend_valid) begin
              rsp_valid <= 1'b1;
              rsp       <= make_rsp(dvrt_pkg::ACT_ENTRY, '0, pend_node, pend_cost, 1'b0);
            end
            pend_valid <= 1'b1;
            pend_node  <= s1_node;
            pend_cost  <= s1_own ? '0 : dvrt_pkg::COST_W'(route_rd.cost);
          end else if (dump_done) begin
            if (pend_valid) begin
              rsp_valid <= 1'b1;
              rsp       <= make_rsp(dvrt_pkg::ACT_ENTRY, '0, pend_node, pend_cost, 1'b1);
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Tables are never written while a dump walks them
  a_no_write_in_dump: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> !route_we && !nb_we)
    else $error("table write during dump");

  // The final dump entry closes the dump
  a_dump_closes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == dvrt_pkg::ACT_ENTRY && rsp.last |-> state == S_IDLE && !pend_valid)
    else $error("dump still open after final entry");

  // The last DV entry always clears the change flag
  a_pending_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_DV && cur.last_entry |=> !change_pending)
    else $error("change flag survives last entry");

  // A forward only follows a neighbor gate lookup
  a_forward_src: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == dvrt_pkg::ACT_FORWARD |-> $past(state) == S_PKT_OUT)
    else $error("forward without gate lookup");

endmodule

`default_nettype wire

// ===== design/distance_vector_route_table.sv =====
`default_nettype none

// Hop-count distance-vector route table. A request is taken when start is high
// and busy is low; it is classified and, unless its type is unused, parked
// in a two-entry queue, so busy rises only when that queue is full. The back
// end then handles one request at a time: a DV entry is decided in S_DV from
// the registered route read; a local packet is answered from S_IDLE, another
// is checked in S_PKT_HOP and, for a forward, sent from S_PKT_OUT after the
// registered read of the neighbor gate table. A hello, or a last DV entry after
// a change, adds a table dump over the first min(NUM_NODES,16) destinations,
// one destination per cycle through the route memory port. Responses appear
// in the cycle after the back end decides them, each on rsp for exactly one
// cycle with rsp_valid high; the receiver cannot stall them, so it must take
// every response as it comes. A dump ends with last set on its final entry.
module distance_vector_route_table #(
  parameter int NUM_NODES = dvrt_pkg::DEF_NUM_NODES,
  parameter int NUM_GATES = dvrt_pkg::DEF_NUM_GATES,
  parameter int COST_BITS = dvrt_pkg::DEF_COST_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire dvrt_pkg::req_t              req,
  input  wire logic                        cfg_we,
  input  wire logic [dvrt_pkg::NODE_W-1:0] cfg_data,
  output logic                             rsp_valid,
  output dvrt_pkg::rsp_t                   rsp
);

  logic [dvrt_pkg::NODE_W-1:0] own_node_id;
  logic                        push;
  dvrt_pkg::job_t              push_job;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_pop;
  dvrt_pkg::job_t              q_job;

  // Own node register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id <= '0;
    end else if (cfg_we) begin
      own_node_id <= cfg_data;
    end
  end

  dvrt_front #(
    .NUM_NODES (NUM_NODES),
    .NUM_GATES (NUM_GATES),
    .COST_BITS (COST_BITS)
  ) u_front (
    .start       (start),
    .req         (req),
    .own_node_id (own_node_id),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .job         (push_job)
  );

  dvrt_queue #(
    .DEPTH (dvrt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_job)
  );

  dvrt_back #(
    .NUM_NODES (NUM_NODES),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .own_node_id (own_node_id),
    .q_empty     (q_empty),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request type that the block ignores
  localparam logic [dvrt_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int COST_LIMIT   = (1 << dvrt_pkg::COST_W) - 1;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b1;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  dvrt_pkg::req_t req_in = '0;
  logic        cfg_we = 1'b0;
  logic [dvrt_pkg::NODE_W-1:0] cfg_data = '0;
  logic        rsp_valid;
  dvrt_pkg::rsp_t rsp;

  // Shadow route table and config
  logic                        route_ok [16];
  logic [dvrt_pkg::COST_W-1:0] route_cost_tbl [16];
  logic [dvrt_pkg::NODE_W-1:0] route_hop [16];
  logic                        nbr_ok [16];
  logic [dvrt_pkg::GATE_W-1:0] nbr_gate [16];
  logic                        change_seen;
  logic [dvrt_pkg::NODE_W-1:0] own_id;

  dvrt_pkg::req_t route_req_q [$];
  dvrt_pkg::rsp_t due_rsp_q [$];

  int n_sent = 0;
  int n_taken = 0;
  int err_count = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  distance_vector_route_table u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req_in),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void table_reset();
    for (int i = 0; i < 16; i++) begin
      route_ok[i]       = 1'b0;
      route_cost_tbl[i] = '0;
      route_hop[i]      = '0;
      nbr_ok[i]         = 1'b0;
      nbr_gate[i]       = '0;
    end
    change_seen = 1'b0;
    own_id      = '0;
  endfunction

  // Table listing: own node at cost 0 plus every valid route, ascending
  function automatic void queue_table_dump();
    dvrt_pkg::rsp_t e;
    int   last_d;
    last_d = 0;
    for (int d = 0; d < dvrt_pkg::DUMP_MAX; d++) begin
      if (d == own_id || route_ok[d]) last_d = d;
    end
    for (int d = 0; d < dvrt_pkg::DUMP_MAX; d++) begin
      if (d == own_id || route_ok[d]) begin
        e.action     = dvrt_pkg::ACT_ENTRY;
        e.out_gate   = '0;
        e.dest_node  = dvrt_pkg::NODE_W'(d);
        e.route_cost = (d == own_id) ? '0 : route_cost_tbl[d];
        e.last       = (d == last_d);
        due_rsp_q.push_back(e);
      end
    end
  endfunction

  // Apply one request to the shadow table and queue its responses
  function automatic void route_predict(input dvrt_pkg::req_t r);
    logic [dvrt_pkg::TOTAL_W-1:0] total;
    dvrt_pkg::rsp_t               e;
    logic [dvrt_pkg::NODE_W-1:0]  s;
    logic [dvrt_pkg::NODE_W-1:0]  d;
    s     = r.sender_node;
    d     = r.destination;
    total = {1'b0, r.advertised_cost} + 1'b1;
    case (r.req_type)
      dvrt_pkg::REQ_HELLO: begin
        if (s != own_id) begin
          route_ok[s]       = 1'b1;
          route_cost_tbl[s] = dvrt_pkg::COST_W'(1);
          route_hop[s]      = s;
          nbr_ok[s]         = 1'b1;
          nbr_gate[s]       = r.arrival_gate;
        end
        queue_table_dump();
      end
      dvrt_pkg::REQ_DV: begin
        if (d != own_id && total <= COST_LIMIT) begin
          if (!route_ok[d] || total[dvrt_pkg::COST_W-1:0] < route_cost_tbl[d]) begin
            route_ok[d]       = 1'b1;
            route_cost_tbl[d] = total[dvrt_pkg::COST_W-1:0];
            route_hop[d]      = s;
            nbr_ok[s]         = 1'b1;
            nbr_gate[s]       = r.arrival_gate;
            change_seen       = 1'b1;
          end else if (route_hop[d] == s
                       && total[dvrt_pkg::COST_W-1:0] > route_cost_tbl[d]) begin
            // current next hop advertises a worse cost: follow it up
            route_cost_tbl[d] = total[dvrt_pkg::COST_W-1:0];
            change_seen       = 1'b1;
          end
        end
        if (r.last_entry) begin
          if (change_seen) queue_table_dump();
          change_seen = 1'b0;
        end
      end
      dvrt_pkg::REQ_PKT: begin
        e.out_gate   = '0;
        e.dest_node  = d;
        e.route_cost = '0;
        e.last       = 1'b1;
        if (d == own_id) begin
          e.action = dvrt_pkg::ACT_LOCAL;
        end else if (route_ok[d] && nbr_ok[route_hop[d]]) begin
          e.action   = dvrt_pkg::ACT_FORWARD;
          e.out_gate = nbr_gate[route_hop[d]];
        end else begin
          e.action = dvrt_pkg::ACT_DROP;
        end
        due_rsp_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  function automatic void check_rsp(input dvrt_pkg::rsp_t got);
    dvrt_pkg::rsp_t want;
    if (due_rsp_q.size() == 0) begin
      $error("response with none pending: action=%0d dest=%0d cost=%0d",
             got.action, got.dest_node, got.route_cost);
      err_count++;
    end else begin
      want = due_rsp_q.pop_front();
      note_field("action", 8'(want.action), 8'(got.action));
      note_field("out_gate", 8'(want.out_gate), 8'(got.out_gate));
      note_field("dest_node", 8'(want.dest_node), 8'(got.dest_node));
      note_field("route_cost", want.route_cost, got.route_cost);
      note_field("last", 8'(want.last), 8'(got.last));
    end
  endfunction

  // Monitor: responses, accepted requests and register writes
  always @(posedge clk) begin
    if (rst) begin
      table_reset();
      n_taken <= 0;
    end else begin
      if (rsp_valid) check_rsp(rsp);
      if (start && !busy) begin
        route_predict(req_in);
        n_taken <= n_taken + 1;
      end
      if (cfg_we) own_id = cfg_data;
    end
  end

  // Driver: holds a request until taken, inserts random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      n_sent <= 0;
    end else if (n_taken == n_sent) begin
      if (route_req_q.size() == 0 || (!steady && $urandom_range(0, 99) < 22)) begin
        start <= 1'b0;
      end else begin
        start  <= 1'b1;
        req_in <= route_req_q.pop_front();
        n_sent <= n_sent + 1;
      end
    end
  end

  function automatic void add_req(input logic [dvrt_pkg::TYPE_W-1:0] t, input int s,
                                  input int g, input int d, input int c, input bit l);
    dvrt_pkg::req_t r;
    r.req_type        = t;
    r.sender_node     = dvrt_pkg::NODE_W'(s);
    r.arrival_gate    = dvrt_pkg::GATE_W'(g);
    r.destination     = dvrt_pkg::NODE_W'(d);
    r.advertised_cost = dvrt_pkg::COST_W'(c);
    r.last_entry      = l;
    route_req_q.push_back(r);
  endfunction

  // Mostly small costs, some near the top, some anywhere
  function automatic int pick_cost();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 12);
    if (p < 85) return $urandom_range(240, 255);
    return $urandom_range(0, 255);
  endfunction

  // Random traffic: hellos, whole distance vectors, packet bursts, some noise
  function automatic void add_traffic(input int n_items);
    int made;
    int kind;
    int len;
    int s;
    int g;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(0, 99);
      s    = $urandom_range(0, 15);
      g    = $urandom_range(0, 7);
      if (kind < 15) begin
        add_req(dvrt_pkg::REQ_HELLO, s, g, $urandom_range(0, 15), $urandom_range(0, 255),
                1'($urandom_range(0, 1)));
        made++;
      end else if (kind < 60) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_req(dvrt_pkg::REQ_DV, s, g, $urandom_range(0, 15), pick_cost(), i == len - 1);
        made += len;
      end else if (kind < 90) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          add_req(dvrt_pkg::REQ_PKT, $urandom_range(0, 15), $urandom_range(0, 7),
                  $urandom_range(0, 15), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        made += len;
      end else if (kind < 96) begin
        // stray entry, last flag at random
        add_req(dvrt_pkg::REQ_DV, s, g, $urandom_range(0, 15), pick_cost(),
                1'($urandom_range(0, 1)));
        made++;
      end else begin
        add_req(REQ_UNUSED, s, g, $urandom_range(0, 15), $urandom_range(0, 255),
                1'($urandom_range(0, 1)));
        made++;
      end
    end
  endfunction

  // Let the queue drain and every response come back, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (route_req_q.size() != 0 || n_taken != n_sent || due_rsp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_own(input int v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= dvrt_pkg::NODE_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed, own node 0 after reset
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 0, 0, 1'b0);          // local delivery
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 5, 0, 1'b0);          // no route: drop
    add_req(dvrt_pkg::REQ_HELLO, 3, 7, 0, 0, 1'b0);
    add_req(dvrt_pkg::REQ_HELLO, 0, 1, 0, 0, 1'b0);        // hello from own node still dumps
    add_req(dvrt_pkg::REQ_DV, 3, 7, 9, 254, 1'b0);         // top cost that fits
    add_req(dvrt_pkg::REQ_DV, 3, 7, 10, 255, 1'b0);        // overflow: skipped
    add_req(dvrt_pkg::REQ_DV, 3, 7, 0, 4, 1'b1);           // own node: skipped, dump on last
    add_req(dvrt_pkg::REQ_DV, 3, 7, 9, 2, 1'b1);           // cheaper
    add_req(dvrt_pkg::REQ_DV, 4, 0, 9, 5, 1'b1);           // worse via other hop: no dump
    add_req(dvrt_pkg::REQ_DV, 3, 7, 9, 7, 1'b1);           // next hop got worse
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 9, 0, 1'b0);
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 15, 0, 1'b0);
    add_req(dvrt_pkg::REQ_DV, 15, 2, 15, 0, 1'b0);
    add_req(dvrt_pkg::REQ_DV, 15, 2, 14, 255, 1'b1);
    add_req(dvrt_pkg::REQ_PKT, 15, 7, 15, 255, 1'b1);
    add_req(REQ_UNUSED, 15, 7, 15, 255, 1'b1);
    add_req(dvrt_pkg::REQ_HELLO, 15, 5, 15, 255, 1'b1);
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 15, 0, 1'b0);
    add_req(dvrt_pkg::REQ_DV, 12, 6, 3, 0, 1'b1);          // equal cost, other hop: no change
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 3, 0, 1'b0);
    wait_idle();

    // Own node at the top: stored route to it is neither listed nor used
    write_own(15);
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 15, 0, 1'b0);
    add_req(dvrt_pkg::REQ_HELLO, 9, 3, 0, 0, 1'b0);
    add_traffic(100);
    wait_idle();

    write_own(3);
    add_req(dvrt_pkg::REQ_PKT, 0, 0, 3, 0, 1'b0);
    add_req(dvrt_pkg::REQ_HELLO, 3, 4, 0, 0, 1'b0);
    add_traffic(100);
    wait_idle();

    // Back-to-back requests, no gaps
    steady = 1'b1;
    write_own(8);
    add_traffic(110);
    wait_idle();
    steady = 1'b0;

    write_own($urandom_range(0, 15));
    add_traffic(110);
    wait_idle();

    if (err_count == 0 && due_rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
